@@ src/wts_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wts_pkg: shared definitions for the wavetable synthesizer
// Field widths, event codes, voice record types and the sine table builder.
// ----------------------------------------------------------------------------
package wts_pkg;

	// Field widths
	localparam int MODE_W   = 2;
	localparam int KEY_W    = 7;
	localparam int VEL_W    = 7;
	localparam int STEP_W   = 24;
	localparam int DAC_W    = 12;
	localparam int SAMPLE_W = 16;
	localparam int FRAC_W   = 16;

	// Parameter defaults
	localparam int VOICES_DEF     = 16;
	localparam int TABLE_BITS_DEF = 8;

	// Event codes on the mode field
	localparam logic [MODE_W-1:0] MODE_TICK     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_NOTE_ON  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_NOTE_OFF = 2'd2;

	// Output scaling
	localparam int MID_CODE = 2048;
	localparam int MAX_CODE = 4095;

	// Sine table constants (Q30 angle and Taylor divisors)
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned ONE_Q30     = 64'd1073741824;
	localparam longint unsigned FULL_SCALE  = 64'd32767;
	localparam int TAYLOR_TERMS = 7;
	localparam longint unsigned TAYLOR_DIV [TAYLOR_TERMS] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
	};

	// One voice record as kept in voice memory
	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [VEL_W-1:0]  vol;
		logic [STEP_W-1:0] inc;
	} voice_ent_t;

	// Control strobes from the sequencer to the voice store
	typedef struct packed {
		logic rd_en;
		logic note_we;
		logic free_clr;
		logic phase_we;
	} store_ctl_t;

	// Build one sine table entry; evaluated at elaboration only
	function automatic logic signed [SAMPLE_W-1:0] sine_entry(input int unsigned idx,
			input int unsigned bits);
		longint unsigned n;
		longint unsigned u;
		longint unsigned x;
		longint unsigned term;
		longint unsigned mag;
		longint s;
		logic neg;
		n = 64'd1 << bits;
		u = 64'(idx) << 2;
		neg = 1'b0;
		// fold into the first quadrant
		if (u >= (n << 1)) begin
			neg = 1'b1;
			u = u - (n << 1);
		end
		if (u > n) begin
			u = (n << 1) - u;
		end
		x = (HALF_PI_Q30 * u) >> bits;
		s = longint'(x);
		term = x;
		for (int k = 0; k < TAYLOR_TERMS; k++) begin
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			term = term / TAYLOR_DIV[k];
			if ((k & 1) == 0) begin
				s = s - longint'(term);
			end else begin
				s = s + longint'(term);
			end
		end
		if (s < 0) begin
			s = 0;
		end
		if (s > longint'(ONE_Q30)) begin
			s = longint'(ONE_Q30);
		end
		mag = (FULL_SCALE * longint'(s)) >> 30;
		return neg ? -SAMPLE_W'(mag) : SAMPLE_W'(mag);
	endfunction

endpackage
`default_nettype wire

@@ src/polyphonic_wavetable_synth.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// polyphonic_wavetable_synth: polyphonic sine wavetable synthesizer
// Note events claim and free voices; sample ticks mix all active voices.
// ----------------------------------------------------------------------------
// A note-on word loads the lowest idle voice directly (dropped when all
// VOICES voices play). A note-off word, or a note-on with zero velocity,
// scans voice memory one voice per cycle before the block takes the next
// word. A sample tick scans the same way and ends only once the last
// product has reached the accumulator, since the sine lookup and the
// volume multiply are pipelined behind the scan. The scan rate is set by
// the single read port of the voice and phase memories.
// A tick delivers its dac_sample word through an output register, so the
// next word is accepted while the sample still waits; a following tick holds
// at its end until that register is free. The table length is
// 2**TABLE_BITS entries; phases wrap at the table end. No clearing pass is
// needed after reset.
module polyphonic_wavetable_synth #(
	parameter int VOICES     = wts_pkg::VOICES_DEF,
	parameter int TABLE_BITS = wts_pkg::TABLE_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           item_valid,
	output logic                                item_ready,
	input  wire logic [wts_pkg::MODE_W-1:0]     mode,
	input  wire logic [wts_pkg::KEY_W-1:0]      key,
	input  wire logic [wts_pkg::VEL_W-1:0]      velocity,
	input  wire logic [wts_pkg::STEP_W-1:0]     phase_step,
	output logic                                sample_valid,
	input  wire logic                           sample_ready,
	output logic [wts_pkg::DAC_W-1:0]           dac_sample
);
	import wts_pkg::*;

	localparam int IDX_W   = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int PHASE_W = TABLE_BITS + FRAC_W;
	localparam int SUM_W   = (PHASE_W > STEP_W) ? PHASE_W : STEP_W;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_FINISH} state_t;

	state_t                     state_q;
	logic [IDX_W-1:0]           rd_idx_q;
	logic                       is_tick_q;
	logic                       found_q;
	logic [KEY_W-1:0]           key_q;
	logic                       sample_valid_q;
	logic [DAC_W-1:0]           dac_q;

	logic                       rd_valid_s1;
	logic [IDX_W-1:0]           idx_s1;
	logic                       val_s2;
	logic                       act_s2;
	logic [VEL_W-1:0]           vol_s2;

	store_ctl_t                 ctl;
	voice_ent_t                 note_ent;
	voice_ent_t                 rd_ent;
	logic                       rd_active;
	logic [PHASE_W-1:0]         rd_phase;
	logic                       free_ok;
	logic [IDX_W-1:0]           free_idx;
	logic [SUM_W-1:0]           phase_sum;
	logic [PHASE_W-1:0]         phase_next;
	logic signed [SAMPLE_W-1:0] rom_data;
	logic                       mix_busy;
	logic [DAC_W-1:0]           level;
	logic                       accept;
	logic                       release_hit;
	logic                       pipe_empty;

	assign accept     = item_valid && item_ready;
	assign item_ready = (state_q == ST_IDLE);

	// first active voice with the key, for a release scan
	assign release_hit = rd_valid_s1 && !is_tick_q && rd_active
		&& (rd_ent.key == key_q) && !found_q;

	// advance the phase, wrapping at the table end
	assign phase_sum  = SUM_W'(rd_phase) + SUM_W'(rd_ent.inc);
	assign phase_next = phase_sum[PHASE_W-1:0];

	assign pipe_empty = !rd_valid_s1 && !val_s2 && !mix_busy;

	// drive the voice store
	always_comb begin
		ctl.rd_en    = (state_q == ST_SCAN);
		ctl.note_we  = accept && (mode == MODE_NOTE_ON) && (velocity != '0) && free_ok;
		ctl.free_clr = release_hit;
		ctl.phase_we = rd_valid_s1 && is_tick_q && rd_active;
		note_ent.key = key;
		note_ent.vol = velocity;
		note_ent.inc = phase_step;
	end

	wts_voice_store #(
		.VOICES  (VOICES),
		.PHASE_W (PHASE_W)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.rd_idx   (rd_idx_q),
		.note_idx (free_idx),
		.note_ent (note_ent),
		.clr_idx  (idx_s1),
		.ph_idx   (idx_s1),
		.ph_data  (phase_next),
		.rd_ent   (rd_ent),
		.rd_active(rd_active),
		.rd_phase (rd_phase),
		.free_ok  (free_ok),
		.free_idx (free_idx)
	);

	wts_sine_rom #(
		.TABLE_BITS (TABLE_BITS)
	) u_rom (
		.clk  (clk),
		.addr (rd_phase[PHASE_W-1:FRAC_W]),
		.data (rom_data)
	);

	wts_mixer #(
		.VOICES (VOICES)
	) u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (accept && (mode == MODE_TICK)),
		.mac_valid (val_s2 && act_s2),
		.sample    (rom_data),
		.vol       (vol_s2),
		.busy      (mix_busy),
		.level     (level)
	);

	// scan pipeline: read, lookup, multiply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
			val_s2      <= 1'b0;
		end else begin
			rd_valid_s1 <= ctl.rd_en;
			val_s2      <= rd_valid_s1 && is_tick_q;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q;
		act_s2 <= rd_active;
		vol_s2 <= rd_ent.vol;
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			rd_idx_q       <= '0;
			is_tick_q      <= 1'b0;
			found_q        <= 1'b0;
			key_q          <= '0;
			sample_valid_q <= 1'b0;
			dac_q          <= '0;
		end else begin
			// drop the sample word once taken, unless a new one loads now
			if (sample_valid_q && sample_ready && (state_q != ST_FINISH)) begin
				sample_valid_q <= 1'b0;
			end
			if (release_hit) begin
				found_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						key_q    <= key;
						found_q  <= 1'b0;
						rd_idx_q <= '0;
						unique case (mode)
							MODE_TICK: begin
								is_tick_q <= 1'b1;
								state_q   <= ST_SCAN;
							end
							MODE_NOTE_ON: begin
								if (velocity == '0) begin
									is_tick_q <= 1'b0;
									state_q   <= ST_SCAN;
								end
							end
							MODE_NOTE_OFF: begin
								is_tick_q <= 1'b0;
								state_q   <= ST_SCAN;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (rd_idx_q == IDX_W'(VOICES - 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						rd_idx_q <= rd_idx_q + IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					if (pipe_empty) begin
						state_q <= is_tick_q ? ST_FINISH : ST_IDLE;
					end
				end
				ST_FINISH: begin
					// hold until the output register is free
					if (!sample_valid_q || sample_ready) begin
						dac_q          <= level;
						sample_valid_q <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign sample_valid = sample_valid_q;
	assign dac_sample   = dac_q;

endmodule
`default_nettype wire

@@ src/wts_sine_rom.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wts_sine_rom: sine lookup table
// Constant table of signed 16-bit sine samples with a registered read port.
// ----------------------------------------------------------------------------
module wts_sine_rom #(
	parameter int TABLE_BITS = wts_pkg::TABLE_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic [TABLE_BITS-1:0]                addr,
	output logic signed [wts_pkg::SAMPLE_W-1:0]       data
);
	import wts_pkg::*;

	localparam int TABLE_SIZE = 1 << TABLE_BITS;

	logic signed [SAMPLE_W-1:0] rom_w [TABLE_SIZE];

	// fill the table from the builder function
	for (genvar i = 0; i < TABLE_SIZE; i++) begin : g_rom
		assign rom_w[i] = sine_entry(i, TABLE_BITS);
	end

	// register the read data
	always_ff @(posedge clk) begin
		data <= rom_w[addr];
	end

endmodule
`default_nettype wire

@@ src/wts_voice_store.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wts_voice_store: voice state memories
// Voice memory (key, volume, increment) and phase memory, each one write and
// one registered read port, plus active and phase-valid flags per voice.
// ----------------------------------------------------------------------------
module wts_voice_store #(
	parameter int VOICES  = wts_pkg::VOICES_DEF,
	parameter int PHASE_W = wts_pkg::TABLE_BITS_DEF + wts_pkg::FRAC_W,
	localparam int IDX_W  = (VOICES > 1) ? $clog2(VOICES) : 1
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire wts_pkg::store_ctl_t    ctl,
	input  wire logic [IDX_W-1:0]       rd_idx,
	input  wire logic [IDX_W-1:0]       note_idx,
	input  wire wts_pkg::voice_ent_t    note_ent,
	input  wire logic [IDX_W-1:0]       clr_idx,
	input  wire logic [IDX_W-1:0]       ph_idx,
	input  wire logic [PHASE_W-1:0]     ph_data,
	output wts_pkg::voice_ent_t         rd_ent,
	output logic                        rd_active,
	output logic [PHASE_W-1:0]          rd_phase,
	output logic                        free_ok,
	output logic [IDX_W-1:0]            free_idx
);
	import wts_pkg::*;

	voice_ent_t         vmem [VOICES];
	logic [PHASE_W-1:0] pmem [VOICES];
	logic [VOICES-1:0]  active_q;
	logic [VOICES-1:0]  pval_q;
	logic               rd_act_q;
	logic               rd_pval_q;
	logic [PHASE_W-1:0] rd_pmem_q;

	// voice memory: written by note on, read by the scan
	always_ff @(posedge clk) begin
		if (ctl.note_we) begin
			vmem[note_idx] <= note_ent;
		end
		if (ctl.rd_en) begin
			rd_ent <= vmem[rd_idx];
		end
	end

	// phase memory: read-modify-write during a sample tick
	always_ff @(posedge clk) begin
		if (ctl.phase_we) begin
			pmem[ph_idx] <= ph_data;
		end
		if (ctl.rd_en) begin
			rd_pmem_q <= pmem[rd_idx];
		end
	end

	// active and phase-valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= '0;
			pval_q    <= '0;
			rd_act_q  <= 1'b0;
			rd_pval_q <= 1'b0;
		end else begin
			if (ctl.note_we) begin
				active_q[note_idx] <= |note_ent.inc;
			end
			if (ctl.free_clr) begin
				active_q[clr_idx] <= 1'b0;
			end
			if (ctl.phase_we) begin
				pval_q[ph_idx] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rd_act_q  <= active_q[rd_idx];
				rd_pval_q <= pval_q[rd_idx];
			end
		end
	end

	assign rd_active = rd_act_q;
	// a phase never written reads as zero
	assign rd_phase  = rd_pval_q ? rd_pmem_q : '0;

	// pick the lowest idle voice
	always_comb begin
		free_ok  = 1'b0;
		free_idx = '0;
		for (int v = VOICES - 1; v >= 0; v--) begin
			if (!active_q[v]) begin
				free_ok  = 1'b1;
				free_idx = IDX_W'(v);
			end
		end
	end

endmodule
`default_nettype wire

@@ src/wts_mixer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wts_mixer: multiply-accumulate and output scaling
// Multiplies one table sample by one voice volume per cycle, accumulates,
// and presents the scaled and saturated 12-bit level.
// ----------------------------------------------------------------------------
module wts_mixer #(
	parameter int VOICES = wts_pkg::VOICES_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 clear,
	input  wire logic                                 mac_valid,
	input  wire logic signed [wts_pkg::SAMPLE_W-1:0]  sample,
	input  wire logic [wts_pkg::VEL_W-1:0]            vol,
	output logic                                      busy,
	output logic [wts_pkg::DAC_W-1:0]                 level
);
	import wts_pkg::*;

	localparam int PROD_W = SAMPLE_W + VEL_W + 1;
	localparam int ACC_W  = PROD_W + $clog2(VOICES) + 1;
	localparam int HI_W   = ACC_W - FRAC_W;
	localparam int LVL_W  = HI_W + DAC_W + 2;

	logic signed [PROD_W-1:0] prod_s3;
	logic                     val_s3;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [LVL_W-1:0]  lvl;

	// register the product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s3 <= 1'b0;
		end else begin
			val_s3 <= mac_valid;
		end
	end

	always_ff @(posedge clk) begin
		prod_s3 <= sample * $signed({1'b0, vol});
	end

	// accumulate, cleared at the start of each tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (clear) begin
			acc_q <= '0;
		end else if (val_s3) begin
			acc_q <= acc_q + ACC_W'(prod_s3);
		end
	end

	assign busy = val_s3;

	// scale by 2^-16, offset to mid code, saturate
	always_comb begin
		lvl = LVL_W'($signed(acc_q[ACC_W-1:FRAC_W])) + LVL_W'(MID_CODE);
		if (lvl < 0) begin
			level = '0;
		end else if (lvl > LVL_W'(MAX_CODE)) begin
			level = DAC_W'(MAX_CODE);
		end else begin
			level = lvl[DAC_W-1:0];
		end
	end

endmodule
`default_nettype wire

@@ src/wts_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wts_checker: port-level checks for the wavetable synthesizer
// Watches the input and sample channels and flags ordering slips.
// ----------------------------------------------------------------------------
module wts_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        item_valid,
	input wire logic                        item_ready,
	input wire logic [wts_pkg::MODE_W-1:0]  mode,
	input wire logic                        sample_valid,
	input wire logic                        sample_ready,
	input wire logic [wts_pkg::DAC_W-1:0]   dac_sample
);
	import wts_pkg::*;

	// a stalled sample word holds
	a_sample_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_ready |=> sample_valid && $stable(dac_sample))
		else $error("sample word changed while stalled");

	// a note event never produces a sample word
	a_note_no_sample: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && (mode != MODE_TICK) && !sample_valid |=> !sample_valid)
		else $error("sample word after a note event");

	// a tick starts a voice scan, so the input stalls next cycle
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && (mode == MODE_TICK) |=> !item_ready)
		else $error("input ready right after a tick");

	// a new sample word only appears at the end of a scan
	a_sample_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sample_valid) |-> !$past(item_ready))
		else $error("sample word without a preceding scan");

endmodule

bind polyphonic_wavetable_synth wts_checker u_wts_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.mode         (mode),
	.sample_valid (sample_valid),
	.sample_ready (sample_ready),
	.dac_sample   (dac_sample)
);
`default_nettype wire

@@ tb/polyphonic_wavetable_synth_test.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// polyphonic_wavetable_synth_test: self-checking bench for the sine synthesizer
// Sends note-on, note-off, sample-tick and unused words, and keeps a shadow set
// of voices and its own sine table. Each dac_sample word is compared with the
// oldest predicted mix.
// ----------------------------------------------------------------------------
module polyphonic_wavetable_synth_test;

	localparam int VOICE_CNT   = wts_pkg::VOICES_DEF;
	localparam int TBL_LEN     = 1 << wts_pkg::TABLE_BITS_DEF;
	localparam int DUE_DEPTH   = 256;
	localparam int TAIL_CYCLES = 4 * (VOICE_CNT + 5);
	localparam int STALL_LIMIT = 1000;
	localparam int RANDOM_WORDS = 1300;

	localparam longint unsigned HALF_PI = 64'd1686629713;
	localparam longint ONE_Q30 = 64'd1073741824;
	localparam longint unsigned PEAK = 64'd32767;
	localparam int MID_LEVEL = 2048;
	localparam int TOP_LEVEL = 4095;

	// mode 3 has no meaning; the block ignores it
	localparam logic [wts_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

	typedef struct {
		logic [wts_pkg::MODE_W-1:0] mode;
		logic [wts_pkg::KEY_W-1:0]  key;
		logic [wts_pkg::VEL_W-1:0]  vel;
		logic [wts_pkg::STEP_W-1:0] step;
		bit drain;
		bit calm;
	} synth_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	logic [wts_pkg::MODE_W-1:0] mode = wts_pkg::MODE_TICK;
	logic [wts_pkg::KEY_W-1:0] key = '0;
	logic [wts_pkg::VEL_W-1:0] velocity = '0;
	logic [wts_pkg::STEP_W-1:0] phase_step = '0;
	logic sample_valid;
	logic sample_ready = 1'b0;
	logic [wts_pkg::DAC_W-1:0] dac_sample;

	// shadow voices and sine table
	logic [wts_pkg::STEP_W-1:0] voice_inc [VOICE_CNT];
	logic [wts_pkg::STEP_W-1:0] voice_phase [VOICE_CNT];
	logic [wts_pkg::VEL_W-1:0] voice_vol [VOICE_CNT];
	logic [wts_pkg::KEY_W-1:0] voice_key [VOICE_CNT];
	logic signed [wts_pkg::SAMPLE_W-1:0] sine_tbl [TBL_LEN];

	synth_word_t word_backlog [$];
	logic [wts_pkg::DAC_W-1:0] sample_due [DUE_DEPTH];
	int n_words = 0;
	int n_sent = 0;
	int n_predicted = 0;
	int n_checked = 0;
	int fails = 0;
	int send_gap = 0;
	int recv_gap = 0;
	int stall_cycles = 0;
	logic calm_run = 1'b0;

	polyphonic_wavetable_synth u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.mode         (mode),
		.key          (key),
		.velocity     (velocity),
		.phase_step   (phase_step),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.dac_sample   (dac_sample)
	);

	always #10 clk = ~clk;

	// One table entry: fold to the first quadrant, Q30 Taylor series, scale
	function automatic logic signed [wts_pkg::SAMPLE_W-1:0] sine_point(input int unsigned idx);
		longint unsigned u;
		longint unsigned x;
		longint unsigned term;
		longint unsigned div;
		longint s;
		longint unsigned mag;
		bit neg;
		u = 64'(idx) * 4;
		neg = 1'b0;
		if (u >= 2 * TBL_LEN) begin
			neg = 1'b1;
			u = u - 2 * TBL_LEN;
		end
		if (u > TBL_LEN) begin
			u = 2 * TBL_LEN - u;
		end
		x = (HALF_PI * u) / TBL_LEN;
		s = longint'(x);
		term = x;
		for (int k = 1; k <= 7; k++) begin
			div = 64'((2 * k) * (2 * k + 1));
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			term = term / div;
			if (k % 2 == 1) begin
				s = s - longint'(term);
			end else begin
				s = s + longint'(term);
			end
		end
		if (s < 0) begin
			s = 0;
		end
		if (s > ONE_Q30) begin
			s = ONE_Q30;
		end
		mag = (PEAK * longint'(s)) >> 30;
		return neg ? -16'(mag) : 16'(mag);
	endfunction

	// Sum all active voices, advance their phases, scale to a 12-bit code
	function automatic logic [wts_pkg::DAC_W-1:0] mix_voices();
		longint acc;
		longint level;
		acc = 0;
		for (int v = 0; v < VOICE_CNT; v++) begin
			if (voice_inc[v] != 0) begin
				// table of 256 entries: index is the integer part of the phase
				acc = acc + longint'(sine_tbl[voice_phase[v][23:16]]) * longint'(voice_vol[v]);
				voice_phase[v] = voice_phase[v] + voice_inc[v];
			end
		end
		level = (acc >>> 16) + MID_LEVEL;
		if (level > TOP_LEVEL) begin
			level = TOP_LEVEL;
		end
		if (level < 0) begin
			level = 0;
		end
		return 12'(level);
	endfunction

	// Load the lowest idle voice; drop the note when every voice plays
	task automatic claim_voice(input logic [6:0] k, input logic [6:0] vel, input logic [23:0] step);
		bit done;
		done = 1'b0;
		for (int v = 0; v < VOICE_CNT && !done; v++) begin
			if (voice_inc[v] == 0) begin
				voice_inc[v] = step;
				voice_key[v] = k;
				voice_vol[v] = vel;
				done = 1'b1;
			end
		end
	endtask

	// Free the lowest active voice on this key; its phase is kept
	task automatic free_voice(input logic [6:0] k);
		bit done;
		done = 1'b0;
		for (int v = 0; v < VOICE_CNT && !done; v++) begin
			if (voice_inc[v] != 0 && voice_key[v] == k) begin
				voice_inc[v] = '0;
				voice_key[v] = '0;
				voice_vol[v] = '0;
				done = 1'b1;
			end
		end
	endtask

	function automatic synth_word_t make_word(input logic [1:0] m, input logic [6:0] k,
			input logic [6:0] vel, input logic [23:0] step);
		synth_word_t w;
		w.mode = m;
		w.key = k;
		w.vel = vel;
		w.step = step;
		w.drain = 1'b0;
		w.calm = 1'b0;
		return w;
	endfunction

	// Driver: predict each accepted word, then present the next one
	always @(posedge clk or negedge arst_n) begin : drive_words
		synth_word_t nxt;
		logic accepted;
		if (!arst_n) begin
			item_valid <= 1'b0;
			mode <= wts_pkg::MODE_TICK;
			key <= '0;
			velocity <= '0;
			phase_step <= '0;
			send_gap <= 0;
			n_sent <= 0;
			n_predicted <= 0;
			calm_run <= 1'b0;
			for (int v = 0; v < VOICE_CNT; v++) begin
				voice_inc[v] = '0;
				voice_phase[v] = '0;
				voice_vol[v] = '0;
				voice_key[v] = '0;
			end
		end else begin
			accepted = item_valid && item_ready;
			if (accepted) begin
				case (mode)
					wts_pkg::MODE_TICK: begin
						sample_due[n_predicted % DUE_DEPTH] <= mix_voices();
						n_predicted <= n_predicted + 1;
					end
					wts_pkg::MODE_NOTE_ON: begin
						if (velocity == 0) begin
							free_voice(key);
						end else begin
							claim_voice(key, velocity, phase_step);
						end
					end
					wts_pkg::MODE_NOTE_OFF: begin
						free_voice(key);
					end
					default: ;
				endcase
			end
			if (!item_valid || accepted) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					item_valid <= 1'b0;
				end else if (word_backlog.size() == 0) begin
					item_valid <= 1'b0;
				end else if (word_backlog[0].drain) begin
					// hold until every predicted sample has come back
					item_valid <= 1'b0;
					if (!accepted && n_checked == n_predicted) begin
						void'(word_backlog.pop_front());
					end
				end else if (!calm_run && !word_backlog[0].calm && $urandom_range(0, 5) == 0) begin
					send_gap <= $urandom_range(0, 5);
					item_valid <= 1'b0;
				end else begin
					nxt = word_backlog.pop_front();
					item_valid <= 1'b1;
					mode <= nxt.mode;
					key <= nxt.key;
					velocity <= nxt.vel;
					phase_step <= nxt.step;
					n_sent <= n_sent + 1;
					if (nxt.calm) begin
						calm_run <= 1'b1;
					end
				end
			end
		end
	end

	// Monitor: check each dac_sample word against the oldest prediction
	always @(posedge clk or negedge arst_n) begin : watch_samples
		logic [wts_pkg::DAC_W-1:0] want;
		if (!arst_n) begin
			sample_ready <= 1'b0;
			recv_gap <= 0;
			n_checked <= 0;
			fails <= 0;
		end else begin
			if (sample_valid && sample_ready) begin
				if (n_checked < n_predicted) begin
					want = sample_due[n_checked % DUE_DEPTH];
					if (dac_sample !== want) begin
						$display("%0t: dac_sample mismatch, expected %0d, actual %0d",
							$time, want, dac_sample);
						fails <= fails + 1;
					end
					n_checked <= n_checked + 1;
				end else begin
					$display("%0t: dac_sample with no tick pending, expected none, actual %0d",
						$time, dac_sample);
					fails <= fails + 1;
				end
			end
			// stall the output side in short bursts
			if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				sample_ready <= 1'b0;
			end else if (!calm_run && $urandom_range(0, 6) == 0) begin
				recv_gap <= $urandom_range(0, 5);
				sample_ready <= 1'b0;
			end else begin
				sample_ready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run when no word moves for too long
	always @(posedge clk) begin : watchdog
		if (!arst_n || (item_valid && item_ready) || (sample_valid && sample_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no word accepted for %0d cycles", $time, STALL_LIMIT);
			$display("polyphonic_wavetable_synth_test: FAIL");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin : run_test
		synth_word_t w;
		logic [6:0] key_pool [12];
		int held [$];
		int r;
		int pick;
		logic [6:0] k;
		logic [6:0] vel;
		logic [23:0] step;

		for (int i = 0; i < TBL_LEN; i++) begin
			sine_tbl[i] = sine_point(i);
		end

		// directed: empty mix, ignored mode, stray note-off
		word_backlog.push_back(make_word(wts_pkg::MODE_TICK, 7'd0, 7'd0, 24'd0));
		word_backlog.push_back(make_word(MODE_UNUSED, 7'd127, 7'd127, 24'hFFFFFF));
		word_backlog.push_back(make_word(wts_pkg::MODE_NOTE_OFF, 7'd5, 7'd0, 24'd0));
		// fill voices at full volume, a quarter table per tick
		for (int i = 0; i < 13; i++) begin
			word_backlog.push_back(make_word(wts_pkg::MODE_NOTE_ON, 7'(i), 7'd127, 24'h400000));
		end
		// oversized increment, then a zero increment that leaves its voice idle
		word_backlog.push_back(make_word(wts_pkg::MODE_NOTE_ON, 7'd127, 7'd127, 24'hFFFFFF));
		word_backlog.push_back(make_word(wts_pkg::MODE_NOTE_ON, 7'd20, 7'd1, 24'd0));
		word_backlog.push_back(make_word(wts_pkg::MODE_NOTE_ON, 7'd21, 7'd127, 24'h400000));
		word_backlog.push_back(make_word(wts_pkg::MODE_NOTE_ON, 7'd22, 7'd127, 24'h400000));
		// all voices busy: this note is dropped
		word_backlog.push_back(make_word(wts_pkg::MODE_NOTE_ON, 7'd23, 7'd5, 24'd1));
		word_backlog.push_back(make_word(wts_pkg::MODE_TICK, 7'd0, 7'd0, 24'd0));
		word_backlog.push_back(make_word(wts_pkg::MODE_TICK, 7'd0, 7'd0, 24'd0));
		// release by note-off and by zero velocity, then reuse a freed voice
		word_backlog.push_back(make_word(wts_pkg::MODE_NOTE_OFF, 7'd0, 7'd0, 24'd0));
		word_backlog.push_back(make_word(wts_pkg::MODE_NOTE_ON, 7'd1, 7'd0, 24'd0));
		word_backlog.push_back(make_word(wts_pkg::MODE_NOTE_ON, 7'd40, 7'd64, 24'h010000));
		word_backlog.push_back(make_word(wts_pkg::MODE_TICK, 7'd0, 7'd0, 24'd0));
		word_backlog.push_back(make_word(wts_pkg::MODE_TICK, 7'd0, 7'd0, 24'd0));
		w = make_word(wts_pkg::MODE_TICK, 7'd0, 7'd0, 24'd0);
		w.drain = 1'b1;
		word_backlog.push_back(w);

		// random: chords built and released on a small key pool, ticks in between
		for (int i = 0; i < 12; i++) begin
			key_pool[i] = 7'($urandom_range(0, 127));
		end
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			r = $urandom_range(0, 99);
			k = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, 11)] : 7'($urandom);
			vel = 7'($urandom);
			step = 24'($urandom);
			if (r < 45) begin
				w = make_word(wts_pkg::MODE_TICK, k, vel, step);
			end else if (r < 70) begin
				if ($urandom_range(0, 9) == 0) begin
					vel = '0;
				end else if (vel == 0) begin
					vel = 7'($urandom_range(1, 127));
				end
				pick = $urandom_range(0, 19);
				if (pick == 0) begin
					step = '0;
				end else if (pick < 17) begin
					step = 24'($urandom_range(1, 24'h03FFFF));
				end
				if (vel != 0) begin
					held.push_back(k);
				end
				w = make_word(wts_pkg::MODE_NOTE_ON, k, vel, step);
			end else if (r < 94) begin
				if (held.size() > 0 && $urandom_range(0, 4) != 0) begin
					pick = $urandom_range(0, held.size() - 1);
					k = 7'(held[pick]);
					held.delete(pick);
				end
				w = make_word(wts_pkg::MODE_NOTE_OFF, k, vel, step);
			end else begin
				w = make_word(MODE_UNUSED, k, vel, step);
			end
			if (i == RANDOM_WORDS - 150) begin
				w.calm = 1'b1;
			end
			word_backlog.push_back(w);
			// one pause mid-run until the output side has caught up
			if (i == RANDOM_WORDS / 2) begin
				w.drain = 1'b1;
				word_backlog.push_back(w);
			end
		end
		foreach (word_backlog[i]) begin
			if (!word_backlog[i].drain) begin
				n_words++;
			end
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// wait for every word to go in and every sample to come out
		@(posedge clk);
		while (n_sent != n_words || item_valid || n_checked != n_predicted) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fails == 0 && n_checked == n_predicted) begin
			$display("polyphonic_wavetable_synth_test: PASS");
		end else begin
			$display("polyphonic_wavetable_synth_test: FAIL");
		end
		$finish;
	end

endmodule
`default_nettype wire
